/* hdl/trilinear_vector_interpolator_macros.svh */
// assertion macros for the trilinear vector interpolator
// expects clk_i and rst_ni in the scope of the module that asserts
`ifndef TRILINEAR_VECTOR_INTERPOLATOR_MACROS_SVH
`define TRILINEAR_VECTOR_INTERPOLATOR_MACROS_SVH

// property must hold at every clock edge out of reset
`define TVI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true out of reset
`define TVI_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* hdl/tvi_pkg.sv */
// shared types and constants of the trilinear vector interpolator
// no dependencies
`default_nettype none

package tvi_pkg;

  localparam int WORD_W    = 32;
  localparam int IDX_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int S_TDATA_W = 136;
  localparam int M_TDATA_W = 96;

  // item kind carried on tuser
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_INTERP = 1'b1
  } op_e;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_ORIGIN_Z = 2'd2,
    REG_EDGE_LEN = 2'd3
  } cfg_reg_e;

  localparam logic [WORD_W-1:0] ORIGIN_X_RST = 32'd655360;
  localparam logic [WORD_W-1:0] ORIGIN_Y_RST = 32'd720896;
  localparam logic [WORD_W-1:0] ORIGIN_Z_RST = 32'd786432;
  localparam logic [WORD_W-1:0] EDGE_LEN_RST = 32'd196608;

endpackage

`default_nettype wire

/* hdl/trilinear_vector_interpolator.sv */
// trilinear vector interpolator: divider pipeline for the cell fractions,
// corner store and three lerp levels; uses tvi_pkg and the assertion macros
//
//   channel   direction  handshake                   payload
//   s_axis    in         s_axis_tvalid/tready        tuser opcode, tdata load/point
//   m_axis    out        m_axis_tvalid/tready        tuser out_of_cell, tdata vector
//   cfg       in         cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// one item per cycle when not stalled, through (FRAC_BITS+1)/3 rounded up + 9 register
// stages, set by the restoring divider that retires up to three quotient bits per stage.
// loads write the corner store as they leave the fraction stage and give no item.
// stalls back up stage by stage; bubbles collapse, nothing is lost or repeated.
// reset clears valid bits and the corner store and restores the configuration defaults at once.
`default_nettype none

`include "trilinear_vector_interpolator_macros.svh"

module trilinear_vector_interpolator
  import tvi_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int COMPONENTS  = 3
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // slave stream
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // value_index[4:0], value_word[36:5], point_x[68:37], point_y[100:69],
  // point_z[132:101], zero fill
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  // opcode[0]
  input  wire logic [0:0]            s_axis_tuser,
  // master stream
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // interp_x[31:0], interp_y[63:32], interp_z[95:64]
  output      logic [M_TDATA_W-1:0]  m_axis_tdata,
  // out_of_cell[0]
  output      logic [0:0]            m_axis_tuser,
  // configuration writes
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [WORD_W-1:0]     cfg_data_i
);

  localparam int SW        = (VALUE_WIDTH < WORD_W) ? VALUE_WIDTH : WORD_W;
  localparam int FW        = FRAC_BITS + 1;
  localparam int PW        = SW + FW + 2;
  localparam int DEPTH     = 8 * COMPONENTS;
  localparam int AW        = $clog2(DEPTH);
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int STEP_PER  = 3;
  localparam int DS        = (DIV_STEPS + STEP_PER - 1) / STEP_PER;
  localparam int ST_IN     = 0;
  localparam int ST_DIFF   = 1;
  localparam int ST_DIV0   = 2;
  localparam int ST_FIN    = ST_DIV0 + DS;
  localparam int ST_M1     = ST_FIN + 1;
  localparam int ST_A1     = ST_FIN + 2;
  localparam int ST_M2     = ST_FIN + 3;
  localparam int ST_A2     = ST_FIN + 4;
  localparam int ST_M3     = ST_FIN + 5;
  localparam int ST_OUT    = ST_FIN + 6;
  localparam int NST       = ST_OUT + 1;

  typedef logic signed [SW-1:0] val_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic [FW-1:0]        frac_t;
  typedef logic [WORD_W:0]      rem_t;

  localparam frac_t FRAC_ONE = frac_t'(1) << FRAC_BITS;

  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
  } ld_t;

  typedef struct packed {
    ld_t                    ld;
    logic [2:0][WORD_W-1:0] pt;
  } in_t;

  typedef struct packed {
    ld_t                  ld;
    logic [2:0][WORD_W:0] d;
    logic [WORD_W-1:0]    elen;
  } diff_t;

  typedef struct packed {
    ld_t               ld;
    logic [2:0]        neg;
    logic [2:0]        hi;
    rem_t [2:0]        r;
    frac_t [2:0]       q;
    logic [WORD_W-1:0] elen;
  } div_t;

  typedef struct packed {
    ld_t         ld;
    frac_t [2:0] f;
    logic        oob;
  } fin_t;

  // lerp halves: product of difference and fraction, then floor add
  function automatic prod_t lerp_mul(val_t a, val_t b, frac_t f);
    logic signed [SW:0] df;
    df = (SW+1)'(b) - (SW+1)'(a);
    return PW'(df) * PW'($signed({1'b0, f}));
  endfunction

  function automatic val_t lerp_add(val_t a, prod_t p);
    prod_t s;
    s = PW'(a) + (p >>> FRAC_BITS);
    return s[SW-1:0];
  endfunction

  // configuration registers
  logic [WORD_W-1:0] org_x_q, org_y_q, org_z_q, elen_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= ORIGIN_X_RST;
      org_y_q <= ORIGIN_Y_RST;
      org_z_q <= ORIGIN_Z_RST;
      elen_q  <= EDGE_LEN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ORIGIN_X: org_x_q <= cfg_data_i;
        REG_ORIGIN_Y: org_y_q <= cfg_data_i;
        REG_ORIGIN_Z: org_z_q <= cfg_data_i;
        REG_EDGE_LEN: elen_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage valids and backpressure chain
  logic [NST-1:0] vld_q;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = m_axis_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[ST_IN];

  in_t   in_q;
  diff_t diff_q;
  div_t  div_q [DS];
  div_t  div_init;
  fin_t  fin_q;
  fin_t  fin_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[ST_IN]) begin
        vld_q[ST_IN] <= s_axis_tvalid;
      end
      for (int k = ST_IN + 1; k < NST; k++) begin
        if (rdy[k]) begin
          if (k == ST_M1) begin
            vld_q[k] <= vld_q[k-1] && (fin_q.ld.op == OP_INTERP);
          end else begin
            vld_q[k] <= vld_q[k-1];
          end
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (rdy[ST_IN]) begin
      in_q.ld.op   <= op_e'(s_axis_tuser[0]);
      in_q.ld.idx  <= s_axis_tdata[4:0];
      in_q.ld.word <= s_axis_tdata[36:5];
      in_q.pt[0]   <= s_axis_tdata[68:37];
      in_q.pt[1]   <= s_axis_tdata[100:69];
      in_q.pt[2]   <= s_axis_tdata[132:101];
    end
  end

  // offsets from the cell corner, zero edge taken as one ulp
  always_ff @(posedge clk_i) begin
    if (rdy[ST_DIFF]) begin
      diff_q.ld   <= in_q.ld;
      diff_q.d[0] <= (WORD_W+1)'($signed(in_q.pt[0])) - (WORD_W+1)'($signed(org_x_q));
      diff_q.d[1] <= (WORD_W+1)'($signed(in_q.pt[1])) - (WORD_W+1)'($signed(org_y_q));
      diff_q.d[2] <= (WORD_W+1)'($signed(in_q.pt[2])) - (WORD_W+1)'($signed(org_z_q));
      diff_q.elen <= (elen_q == '0) ? WORD_W'(1) : elen_q;
    end
  end

  // divider setup: negative offsets and offsets not below the doubled edge length clamp early
  always_comb begin
    div_init.ld   = diff_q.ld;
    div_init.elen = diff_q.elen;
    for (int a = 0; a < 3; a++) begin
      div_init.neg[a] = diff_q.d[a][WORD_W];
      div_init.hi[a]  = !diff_q.d[a][WORD_W] &&
                        ({1'b0, diff_q.d[a][WORD_W-1:0]} >= {diff_q.elen, 1'b0});
      div_init.r[a]   = (div_init.neg[a] || div_init.hi[a]) ? '0
                        : {1'b0, diff_q.d[a][WORD_W-1:0]};
      div_init.q[a]   = '0;
    end
  end

  // restoring divider, up to three quotient bits per stage
  for (genvar gs = 0; gs < DS; gs++) begin : g_div
    div_t src;
    div_t nx;

    if (gs == 0) begin : g_first
      assign src = div_init;
    end else begin : g_next
      assign src = div_q[gs-1];
    end

    always_comb begin
      nx = src;
      for (int j = 0; j < STEP_PER; j++) begin
        if (gs * STEP_PER + j < DIV_STEPS) begin
          for (int a = 0; a < 3; a++) begin
            if (nx.r[a] >= {1'b0, nx.elen}) begin
              nx.r[a] = nx.r[a] - {1'b0, nx.elen};
              nx.q[a] = {nx.q[a][FW-2:0], 1'b1};
            end else begin
              nx.q[a] = {nx.q[a][FW-2:0], 1'b0};
            end
            nx.r[a] = {nx.r[a][WORD_W-1:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[ST_DIV0+gs]) begin
        div_q[gs] <= nx;
      end
    end
  end

  // final clamp of each fraction to [0, one]
  always_comb begin
    logic over;
    fin_d.ld  = div_q[DS-1].ld;
    fin_d.oob = 1'b0;
    for (int a = 0; a < 3; a++) begin
      over = div_q[DS-1].q[a] > FRAC_ONE;
      if (div_q[DS-1].neg[a]) begin
        fin_d.f[a] = '0;
      end else if (div_q[DS-1].hi[a] || over) begin
        fin_d.f[a] = FRAC_ONE;
      end else begin
        fin_d.f[a] = div_q[DS-1].q[a];
      end
      fin_d.oob = fin_d.oob || div_q[DS-1].neg[a] || div_q[DS-1].hi[a] || over;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_FIN]) begin
      fin_q <= fin_d;
    end
  end

  // corner store, written by loads in stream order
  val_t store_q [DEPTH];
  logic store_we;

  assign store_we = vld_q[ST_FIN] && rdy[ST_M1] && (fin_q.ld.op == OP_LOAD) &&
                    ((IDX_W+1)'(fin_q.ld.idx) < (IDX_W+1)'(DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        store_q[i] <= '0;
      end
    end else if (store_we) begin
      store_q[fin_q.ld.idx[AW-1:0]] <= $signed(fin_q.ld.word[SW-1:0]);
    end
  end

  // lerp pipeline registers
  prod_t p1_q [COMPONENTS][4];
  val_t  a1_q [COMPONENTS][4];
  val_t  l1_q [COMPONENTS][4];
  prod_t p2_q [COMPONENTS][2];
  val_t  a2_q [COMPONENTS][2];
  val_t  l2_q [COMPONENTS][2];
  prod_t p3_q [COMPONENTS];
  val_t  a3_q [COMPONENTS];
  val_t  res_q [COMPONENTS];
  frac_t fy_m1_q, fz_m1_q, fy_a1_q, fz_a1_q, fz_m2_q, fz_a2_q;
  logic  oob_m1_q, oob_a1_q, oob_m2_q, oob_a2_q, oob_m3_q, oob_out_q;

  // x lerps along the corner pairs, then y, then z
  always_ff @(posedge clk_i) begin
    if (rdy[ST_M1]) begin
      for (int c = 0; c < COMPONENTS; c++) begin
        for (int k = 0; k < 4; k++) begin
          p1_q[c][k] <= lerp_mul(store_q[k*COMPONENTS+c], store_q[(k+4)*COMPONENTS+c],
                                 fin_q.f[0]);
          a1_q[c][k] <= store_q[k*COMPONENTS+c];
        end
      end
      fy_m1_q  <= fin_q.f[1];
      fz_m1_q  <= fin_q.f[2];
      oob_m1_q <= fin_q.oob;
    end
    if (rdy[ST_A1]) begin
      for (int c = 0; c < COMPONENTS; c++) begin
        for (int k = 0; k < 4; k++) begin
          l1_q[c][k] <= lerp_add(a1_q[c][k], p1_q[c][k]);
        end
      end
      fy_a1_q  <= fy_m1_q;
      fz_a1_q  <= fz_m1_q;
      oob_a1_q <= oob_m1_q;
    end
    if (rdy[ST_M2]) begin
      for (int c = 0; c < COMPONENTS; c++) begin
        for (int k = 0; k < 2; k++) begin
          p2_q[c][k] <= lerp_mul(l1_q[c][k], l1_q[c][k+2], fy_a1_q);
          a2_q[c][k] <= l1_q[c][k];
        end
      end
      fz_m2_q  <= fz_a1_q;
      oob_m2_q <= oob_a1_q;
    end
    if (rdy[ST_A2]) begin
      for (int c = 0; c < COMPONENTS; c++) begin
        for (int k = 0; k < 2; k++) begin
          l2_q[c][k] <= lerp_add(a2_q[c][k], p2_q[c][k]);
        end
      end
      fz_a2_q  <= fz_m2_q;
      oob_a2_q <= oob_m2_q;
    end
    if (rdy[ST_M3]) begin
      for (int c = 0; c < COMPONENTS; c++) begin
        p3_q[c] <= lerp_mul(l2_q[c][0], l2_q[c][1], fz_a2_q);
        a3_q[c] <= l2_q[c][0];
      end
      oob_m3_q <= oob_a2_q;
    end
    if (rdy[ST_OUT]) begin
      for (int c = 0; c < COMPONENTS; c++) begin
        res_q[c] <= lerp_add(a3_q[c], p3_q[c]);
      end
      oob_out_q <= oob_m3_q;
    end
  end

  // output packing, missing components read as zero
  for (genvar gc = 0; gc < 3; gc++) begin : g_out
    if (gc < COMPONENTS) begin : g_used
      assign m_axis_tdata[gc*WORD_W +: WORD_W] = WORD_W'(res_q[gc]);
    end else begin : g_zero
      assign m_axis_tdata[gc*WORD_W +: WORD_W] = '0;
    end
  end

  assign m_axis_tvalid   = vld_q[ST_OUT];
  assign m_axis_tuser[0] = oob_out_q;

  // checks
  `TVI_ASSERT(a_load_dropped,
    vld_q[ST_FIN] && rdy[ST_M1] && fin_q.ld.op == OP_LOAD |=> !vld_q[ST_M1],
    "load item entered the lerp stages")
  `TVI_ASSERT(a_frac_bounded,
    vld_q[ST_M1] |-> fy_m1_q <= FRAC_ONE && fz_m1_q <= FRAC_ONE,
    "fraction above one")
  `TVI_ASSERT(a_ready_drained,
    !vld_q[ST_OUT] |-> s_axis_tready,
    "input stalled with empty output stage")
  `TVI_ASSERT_NEVER(a_clamp_excl,
    vld_q[ST_DIV0] && (|(div_q[0].neg & div_q[0].hi)),
    "axis clamped both low and high")

endmodule

`default_nettype wire

/* test/trilinear_vector_interpolator_test.sv */
// testbench for the trilinear vector interpolator: corner loads, point queries,
// register writes; depends on tvi_pkg and the block's rtl
`timescale 1ns / 1ps

module trilinear_vector_interpolator_test;
  import tvi_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 15;
  localparam longint ONE = 64'sd1 << FRAC;

  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic        clamped;
  } vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [WORD_W-1:0] cfg_data_i = '0;

  int errors = 0;
  bit long_hold = 1'b0;

  trilinear_vector_interpolator u_top (.*);

  // fixed point model of the cell: fraction per axis, seven lerps per component
  class vector_field_scoreboard;
    longint corners[24];
    logic [31:0] origin[3];
    logic [31:0] edge_len;
    vec_t pending[$];

    function new();
      foreach (corners[i]) corners[i] = 0;
      origin[0] = ORIGIN_X_RST;
      origin[1] = ORIGIN_Y_RST;
      origin[2] = ORIGIN_Z_RST;
      edge_len = EDGE_LEN_RST;
    endfunction

    function void write_reg(cfg_reg_e r, logic [31:0] v);
      if (r == REG_EDGE_LEN) edge_len = v;
      else origin[r] = v;
    endfunction

    function longint axis_frac(logic [31:0] pt, logic [31:0] org, ref bit clamped);
      longint d;
      longint unsigned e, q;
      d = longint'(signed'(pt)) - longint'(signed'(org));
      e = (edge_len == 0) ? 1 : edge_len;
      if (d < 0) begin
        clamped = 1'b1;
        return 0;
      end
      q = (unsigned'(d) << FRAC) / e;
      if (q > ONE) begin
        clamped = 1'b1;
        return ONE;
      end
      return q;
    endfunction

    // floor of a + (b-a)*f / 2^FRAC
    function longint blend(longint a, longint b, longint f);
      longint diff;
      longint unsigned mag, prod;
      diff = b - a;
      mag = diff < 0 ? -diff : diff;
      prod = mag * f;
      if (diff < 0) return a - longint'((prod + ONE - 1) >> FRAC);
      return a + longint'(prod >> FRAC);
    endfunction

    function void note_item(op_e op, logic [S_TDATA_W-1:0] d);
      bit clamped;
      longint f[3];
      longint v[8];
      longint lo, hi;
      logic [31:0] r[3];
      if (op == OP_LOAD) begin
        if (d[4:0] < 24) corners[d[4:0]] = longint'(signed'(d[36:5]));
        return;
      end
      clamped = 1'b0;
      f[0] = axis_frac(d[68:37], origin[0], clamped);
      f[1] = axis_frac(d[100:69], origin[1], clamped);
      f[2] = axis_frac(d[132:101], origin[2], clamped);
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 8; k++) v[k] = corners[k*3+c];
        lo = blend(blend(v[0], v[4], f[0]), blend(v[2], v[6], f[0]), f[1]);
        hi = blend(blend(v[1], v[5], f[0]), blend(v[3], v[7], f[0]), f[1]);
        r[c] = 32'(blend(lo, hi, f[2]));
      end
      pending.push_back('{r[0], r[1], r[2], clamped});
    endfunction

    function int check_result(logic [95:0] d, logic u);
      vec_t want;
      int bad;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item exp none act %h/%b", $time, d, u);
        return 1;
      end
      want = pending.pop_front();
      bad = 0;
      if (d[31:0] !== want.vx) begin
        $display("%0t: interp_x exp %h act %h", $time, want.vx, d[31:0]); bad++;
      end
      if (d[63:32] !== want.vy) begin
        $display("%0t: interp_y exp %h act %h", $time, want.vy, d[63:32]); bad++;
      end
      if (d[95:64] !== want.vz) begin
        $display("%0t: interp_z exp %h act %h", $time, want.vz, d[95:64]); bad++;
      end
      if (u !== want.clamped) begin
        $display("%0t: out_of_cell exp %b act %b", $time, want.clamped, u); bad++;
      end
      return bad;
    endfunction
  endclass

  vector_field_scoreboard field_sb = new();

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200000;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stall pattern, one long hold-off on request
  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        errors += field_sb.check_result(m_axis_tdata, m_axis_tuser[0]);
      if (long_hold) begin
        long_hold <= 1'b0;
        m_axis_tready <= 1'b0;
        hold = 60;
        while (hold > 0) begin
          @(posedge clk_i);
          hold--;
        end
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 15) < 4) ? 1'b0 : 1'b1;
      end
    end
  end

  int gap_left = 0;
  int burst_left = 0;

  task automatic send_item(op_e op, logic [S_TDATA_W-1:0] d);
    // idle gaps between bursts
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
    end
    while (gap_left > 0) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      gap_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    field_sb.note_item(op, d);
    burst_left--;
  endtask

  task automatic idle_out();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (field_sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    field_sb.write_reg(r, v);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [S_TDATA_W-1:0] load_data(logic [4:0] idx, logic [31:0] w);
    logic [S_TDATA_W-1:0] d = '0;
    d[4:0] = idx;
    d[36:5] = w;
    return d;
  endfunction

  function automatic logic [S_TDATA_W-1:0] point_data(logic [31:0] x, logic [31:0] y,
                                                      logic [31:0] z);
    logic [S_TDATA_W-1:0] d = '0;
    d[68:37] = x;
    d[100:69] = y;
    d[132:101] = z;
    return d;
  endfunction

  // point near the cell: mostly inside, sometimes past either face
  function automatic logic [31:0] near_point(logic [31:0] org, logic [31:0] len);
    longint span = (len == 0) ? 1 : longint'(len);
    longint p;
    case ($urandom_range(0, 9))
      0: p = longint'(signed'(org)) - $urandom_range(1, 1 << 20);
      1: p = longint'(signed'(org)) + span + $urandom_range(1, 1 << 20);
      2: return $urandom;
      default: p = longint'(signed'(org)) + (span * $urandom_range(0, 1024)) / 1024;
    endcase
    return p[31:0];
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0)
        send_item(OP_LOAD, load_data(5'($urandom_range(0, 31)), $urandom));
      else if ($urandom_range(0, 7) == 0)
        send_item(OP_INTERP, point_data($urandom, $urandom, $urandom) |
                  load_data(5'($urandom_range(0, 31)), $urandom));
      else
        send_item(OP_INTERP, point_data(near_point(field_sb.origin[0], field_sb.edge_len),
                                        near_point(field_sb.origin[1], field_sb.edge_len),
                                        near_point(field_sb.origin[2], field_sb.edge_len)));
    end
  endtask

  initial begin
    logic [31:0] ext[4];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corners at extremes, queries at corners, inside and outside
    send_item(OP_INTERP, point_data(32'h000A_0000, 32'h000B_0000, 32'h000C_0000));
    for (int i = 0; i < 24; i++)
      send_item(OP_LOAD, load_data(5'(i), (i % 3 == 0) ? 32'h7FFF_FFFF :
                                          (i % 3 == 1) ? 32'h8000_0000 : $urandom));
    send_item(OP_LOAD, load_data(5'd31, 32'hFFFF_FFFF));
    send_item(OP_INTERP, point_data(32'h000D_0000, 32'h000E_0000, 32'h000F_0000));
    send_item(OP_INTERP, point_data(32'h000B_8000, 32'h000C_4000, 32'h000D_2000));
    send_item(OP_INTERP, point_data(32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
    send_item(OP_INTERP, point_data(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
    idle_out();

    // register extremes, followed by random traffic
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    write_reg(REG_EDGE_LEN, 32'h0);
    random_phase(40);
    idle_out();
    write_reg(REG_ORIGIN_X, ext[0]);
    write_reg(REG_ORIGIN_Y, ext[1]);
    write_reg(REG_ORIGIN_Z, ext[2]);
    write_reg(REG_EDGE_LEN, ext[3]);
    random_phase(60);
    idle_out();
    write_reg(REG_ORIGIN_X, 32'hFFF0_0000);
    write_reg(REG_ORIGIN_Y, 32'h0);
    write_reg(REG_ORIGIN_Z, 32'h0010_0000);
    write_reg(REG_EDGE_LEN, 32'h1);
    random_phase(60);
    long_hold <= 1'b1;
    random_phase(60);
    idle_out();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_ORIGIN_X, $urandom);
      write_reg(REG_ORIGIN_Y, $urandom);
      write_reg(REG_ORIGIN_Z, $urandom);
      write_reg(REG_EDGE_LEN, ($urandom_range(0, 1) == 0) ? $urandom_range(1, 1 << 20)
                                                          : $urandom);
      random_phase(100);
      idle_out();
    end
    write_reg(REG_ORIGIN_X, ORIGIN_X_RST);
    write_reg(REG_ORIGIN_Y, ORIGIN_Y_RST);
    write_reg(REG_ORIGIN_Z, ORIGIN_Z_RST);
    write_reg(REG_EDGE_LEN, EDGE_LEN_RST);
    random_phase(60);
    idle_out();

    if (errors == 0 && field_sb.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
